FILE: sv/gscs_pkg.sv
// gscs_pkg: shared types, constants and Q16.16 helpers for the cubic spline evaluator
// used by gscs_seq, gscs_horner and geometric_grid_cubic_spline_eval
`default_nettype none
package gscs_pkg;

  localparam int MaxAlphasDef = 16;
  localparam int NumAlphasReset = 16;

  localparam logic signed [95:0] Q48Max = 96'sh0000_0000_0000_7FFF_FFFF_FFFF;
  localparam logic signed [95:0] Q48Min = -96'sh0000_0000_0000_8000_0000_0000;

  typedef enum logic [1:0] {
    OP_KNOT = 2'd0,
    OP_COEF = 2'd1,
    OP_EVAL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_SETUP,
    S_ISSUE
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] set_index;
    logic       last_of_run;
    logic       batch_end;
  } tag_t;

  function automatic logic signed [47:0] sat48(input logic signed [95:0] v);
    logic signed [47:0] r;
    if (v > Q48Max) begin
      r = Q48Max[47:0];
    end else if (v < Q48Min) begin
      r = Q48Min[47:0];
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  // floor shift of an exact product back to q32.16 (16 fraction bits), saturated to 48 bits
  function automatic logic signed [47:0] qshift(input logic signed [95:0] p);
    return sat48(p >>> 16);
  endfunction

  // join the two partial products of dq * h and add the coefficient
  function automatic logic signed [47:0] hmerge(input logic signed [56:0] hh,
                                                input logic signed [57:0] hl,
                                                input logic signed [31:0] c);
    logic signed [95:0] full;
    full = (96'(hh) <<< 24) + 96'(hl);
    return sat48(96'(c) + 96'(qshift(full)));
  endfunction

endpackage
`default_nettype wire

FILE: sv/gscs_ram.sv
// gscs_ram: generic single write port ram with registered read and read enable
// no dependencies
`default_nettype none
module gscs_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: sv/gscs_seq.sv
// gscs_seq: request decode, knot table, interval search and per-set issue sequencer
// depends on gscs_pkg
`default_nettype none
module gscs_seq #(
  parameter int MaxAlphas = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       opcode,
  input  wire logic [9:0]                       address,
  input  wire logic signed [31:0]               operand,
  input  wire logic                             last_point,
  input  wire logic [4:0]                       num_alphas,
  input  wire logic                             en,
  output logic                                  coef_we,
  output logic [1:0]                            coef_sel,
  output logic [$clog2(MaxAlphas*MaxAlphas)-1:0] coef_row,
  output logic [31:0]                           coef_data,
  output gscs_pkg::tag_t                        iss_tag,
  output logic [$clog2(MaxAlphas*MaxAlphas)-1:0] iss_row,
  output logic signed [32:0]                    iss_dq,
  output logic signed [34:0]                    iss_dq3
);
  import gscs_pkg::*;

  localparam int KW = $clog2(MaxAlphas);
  localparam int CW = $clog2(MaxAlphas + 1);
  localparam int RW = $clog2(MaxAlphas * MaxAlphas);
  localparam int CoefDepth = 4 * MaxAlphas * MaxAlphas;
  localparam int CAW = $clog2(CoefDepth);

  seq_state_t state, state_next;
  logic signed [31:0] knot [MaxAlphas];
  logic signed [31:0] x;
  logic               lp;
  logic [MaxAlphas-1:0] below;
  logic [KW-1:0]      iv_w;
  logic signed [32:0] dq_w;
  logic signed [32:0] dq;
  logic signed [34:0] dq3;
  logic [RW-1:0]      row;
  logic [KW-1:0]      set_cnt;
  logic [CW-1:0]      count;
  logic [31:0]        addr_ext;
  logic               accept;
  logic               final_set;

  assign addr_ext = 32'(address);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (32'(num_alphas) < 32'd2) begin
      count = CW'(2);
    end else if (32'(num_alphas) > 32'(MaxAlphas)) begin
      count = CW'(MaxAlphas);
    end else begin
      count = CW'(num_alphas);
    end
  end

  // coefficient writes go straight to the rams, one ram per power
  assign coef_we   = accept && (op_t'(opcode) == OP_COEF) && (addr_ext < 32'(CoefDepth));
  assign coef_sel  = address[1:0];
  assign coef_row  = addr_ext[CAW-1:2];
  assign coef_data = operand;

  always_ff @(posedge clk) begin
    if (accept && (op_t'(opcode) == OP_KNOT) && (addr_ext < 32'(MaxAlphas))) begin
      knot[addr_ext[KW-1:0]] <= operand;
    end
  end

  // highest index below count whose knot is not above x wins, index 0 when none qualifies
  always_comb begin
    iv_w = '0;
    for (int a = 0; a < MaxAlphas; a++) begin
      if (below[a]) begin
        iv_w = KW'(a);
      end
    end
    dq_w = 33'(x) - 33'(knot[iv_w]);
  end

  assign final_set = (32'(set_cnt) + 32'd1 == 32'(count));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && (op_t'(opcode) == OP_EVAL)) begin
          state_next = S_FIND;
        end
      end
      S_FIND:  state_next = S_SETUP;
      S_SETUP: state_next = S_ISSUE;
      S_ISSUE: begin
        if (en && final_set) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x  <= operand;
      lp <= last_point;
    end
    if (state == S_FIND) begin
      for (int a = 0; a < MaxAlphas; a++) begin
        below[a] <= (knot[a] <= x) && (a < 32'(count));
      end
    end
    if (state == S_SETUP) begin
      dq      <= dq_w;
      dq3     <= (35'(dq_w) <<< 1) + 35'(dq_w);
      row     <= RW'(iv_w);
      set_cnt <= '0;
    end else if (state == S_ISSUE && en) begin
      row     <= row + RW'(count);
      set_cnt <= set_cnt + KW'(1);
    end
  end

  always_comb begin
    iss_tag.valid       = (state == S_ISSUE);
    iss_tag.set_index   = 4'(set_cnt);
    iss_tag.last_of_run = final_set;
    iss_tag.batch_end   = final_set && lp;
  end
  assign iss_row = row;
  assign iss_dq  = dq;
  assign iss_dq3 = dq3;
endmodule
`default_nettype wire

FILE: sv/gscs_horner.sv
// gscs_horner: coefficient rams and the pipelined horner value and slope datapath
// depends on gscs_pkg and gscs_ram
`default_nettype none
module gscs_horner #(
  parameter int MaxAlphas = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              coef_we,
  input  wire logic [1:0]                        coef_sel,
  input  wire logic [$clog2(MaxAlphas*MaxAlphas)-1:0] coef_row,
  input  wire logic [31:0]                       coef_data,
  input  wire gscs_pkg::tag_t                    iss_tag,
  input  wire logic [$clog2(MaxAlphas*MaxAlphas)-1:0] iss_row,
  input  wire logic signed [32:0]                iss_dq,
  input  wire logic signed [34:0]                iss_dq3,
  output gscs_pkg::tag_t                         out_tag,
  output logic signed [47:0]                     value,
  output logic signed [47:0]                     slope
);
  import gscs_pkg::*;

  localparam int Rows = MaxAlphas * MaxAlphas;
  localparam int NStage = 7;

  tag_t tag [NStage];
  logic [31:0] rd [4];

  // dq travels with each set, the next item may load a new one
  logic signed [32:0] dq_r, dq_a, dq_b, dq_c, dq_d;
  logic signed [34:0] dq3_r;
  logic signed [31:0] c0_a, c1_a, c2_a, c0_b, c1_b, c0_c, c1_c, c0_d, c0_e;
  logic signed [64:0] p3;
  logic signed [66:0] p3s;
  logic signed [47:0] h1, s1, h2, s2, s2_e;
  logic signed [56:0] hh_c, sh_c, hh_e;
  logic signed [57:0] hl_c, sl_c, hl_e;

  for (genvar k = 0; k < 4; k++) begin : g_ram
    gscs_ram #(.Width(32), .Depth(Rows)) u_ram (
      .clk  (clk),
      .we   (coef_we && (coef_sel == 2'(k))),
      .waddr(coef_row),
      .wdata(coef_data),
      .re   (en),
      .raddr(iss_row),
      .rdata(rd[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NStage; i++) begin
        tag[i].valid <= 1'b0;
      end
    end else if (en) begin
      tag[0].valid <= iss_tag.valid;
      for (int i = 1; i < NStage; i++) begin
        tag[i].valid <= tag[i-1].valid;
      end
    end
    if (en) begin
      tag[0].set_index   <= iss_tag.set_index;
      tag[0].last_of_run <= iss_tag.last_of_run;
      tag[0].batch_end   <= iss_tag.batch_end;
      for (int i = 1; i < NStage; i++) begin
        tag[i].set_index   <= tag[i-1].set_index;
        tag[i].last_of_run <= tag[i-1].last_of_run;
        tag[i].batch_end   <= tag[i-1].batch_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dq_r  <= iss_dq;
      dq3_r <= iss_dq3;
      // products with c3
      p3   <= dq_r * $signed(rd[3]);
      p3s  <= dq3_r * $signed(rd[3]);
      dq_a <= dq_r;
      c0_a <= $signed(rd[0]);
      c1_a <= $signed(rd[1]);
      c2_a <= $signed(rd[2]);
      // first horner step for value and slope
      h1   <= sat48(96'(c2_a) + 96'(qshift(96'(p3))));
      s1   <= sat48((96'(c2_a) <<< 1) + 96'(qshift(96'(p3s))));
      dq_b <= dq_a;
      c0_b <= c0_a;
      c1_b <= c1_a;
      // split 48-bit operands into two halves
      hh_c <= dq_b * $signed(h1[47:24]);
      hl_c <= dq_b * $signed({1'b0, h1[23:0]});
      sh_c <= dq_b * $signed(s1[47:24]);
      sl_c <= dq_b * $signed({1'b0, s1[23:0]});
      dq_c <= dq_b;
      c0_c <= c0_b;
      c1_c <= c1_b;
      h2   <= hmerge(hh_c, hl_c, c1_c);
      s2   <= hmerge(sh_c, sl_c, c1_c);
      dq_d <= dq_c;
      c0_d <= c0_c;
      hh_e <= dq_d * $signed(h2[47:24]);
      hl_e <= dq_d * $signed({1'b0, h2[23:0]});
      s2_e <= s2;
      c0_e <= c0_d;
      value <= hmerge(hh_e, hl_e, c0_e);
      slope <= s2_e;
    end
  end

  assign out_tag = tag[NStage-1];
endmodule
`default_nettype wire

FILE: sv/geometric_grid_cubic_spline_eval.sv
// geometric_grid_cubic_spline_eval: piecewise cubic spline evaluator, q16.16 in, 48-bit out
// a knot or coefficient write is taken while idle; an evaluate request gives one result per set,
// and no new request is taken until the last set of the current one has been issued
// (search and setup, then one set per cycle through the seven-stage horner pipeline while
// the output is not stalled); rst is synchronous and clears control state and sets
// num_alphas to 16; tables are undefined until written
`default_nettype none
module geometric_grid_cubic_spline_eval #(
  parameter int MAX_ALPHAS = gscs_pkg::MaxAlphasDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         opcode,
  input  wire logic [9:0]         address,
  input  wire logic signed [31:0] operand,
  input  wire logic               last_point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              set_index,
  output logic signed [47:0]      spline_value,
  output logic signed [47:0]      spline_slope,
  output logic                    last_of_run,
  output logic                    batch_end
);
  import gscs_pkg::*;

  localparam int RW = $clog2(MAX_ALPHAS * MAX_ALPHAS);

  logic [4:0]         num_alphas;
  logic               en;
  logic               coef_we;
  logic [1:0]         coef_sel;
  logic [RW-1:0]      coef_row;
  logic [31:0]        coef_data;
  tag_t               iss_tag;
  tag_t               out_tag;
  logic [RW-1:0]      iss_row;
  logic signed [32:0] iss_dq;
  logic signed [34:0] iss_dq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_alphas <= 5'(NumAlphasReset);
    end else if (cfg_we) begin
      num_alphas <= cfg_data;
    end
  end

  // issue and horner pipeline hold while a valid output is stalled
  assign en = !(out_tag.valid && out_stall);

  gscs_seq #(.MaxAlphas(MAX_ALPHAS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .address   (address),
    .operand   (operand),
    .last_point(last_point),
    .num_alphas(num_alphas),
    .en        (en),
    .coef_we   (coef_we),
    .coef_sel  (coef_sel),
    .coef_row  (coef_row),
    .coef_data (coef_data),
    .iss_tag   (iss_tag),
    .iss_row   (iss_row),
    .iss_dq    (iss_dq),
    .iss_dq3   (iss_dq3)
  );

  gscs_horner #(.MaxAlphas(MAX_ALPHAS)) u_horner (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .coef_we  (coef_we),
    .coef_sel (coef_sel),
    .coef_row (coef_row),
    .coef_data(coef_data),
    .iss_tag  (iss_tag),
    .iss_row  (iss_row),
    .iss_dq   (iss_dq),
    .iss_dq3  (iss_dq3),
    .out_tag  (out_tag),
    .value    (spline_value),
    .slope    (spline_slope)
  );

  assign out_valid   = out_tag.valid;
  assign set_index   = out_tag.set_index;
  assign last_of_run = out_tag.last_of_run;
  assign batch_end   = out_tag.batch_end;
endmodule
`default_nettype wire
